// ----- rtl/grc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the grid ray caster.
package grc_pkg;

    // Default grid side in cells
    localparam int GRID_SIDE_DEF = 256;

    // Field widths
    localparam int COORD_W  = 11;
    localparam int CELL_W   = 2;
    localparam int RANGE_W  = 24;
    localparam int CSIZE_W  = 16;
    localparam int OUTC_W   = 3;
    localparam int OP_W     = 1;

    // Hit range arithmetic widths
    localparam int MAG_W    = COORD_W;            // |dx|, |dy|
    localparam int SQ_W     = 2 * MAG_W;          // dx*dx
    localparam int D2_W     = SQ_W + 1;           // dx*dx + dy*dy
    localparam int P1_W     = D2_W + CSIZE_W;     // d2 * cs
    localparam int P2_W     = P1_W + CSIZE_W;     // d2 * cs * cs
    localparam int SQ_IN_W  = P2_W + 1;           // even radicand width
    localparam int ROOT_W   = SQ_IN_W / 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 1'b1;
    localparam int CFG_DATA_W = RANGE_W;

    localparam logic [CSIZE_W-1:0] CELL_SIZE_RST = 16'd3277;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 24'd1966080;
    localparam logic [RANGE_W-1:0] RANGE_SAT     = 24'hFFFFFF;

    // Operations
    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;

    // Cell states
    localparam logic [CELL_W-1:0] CELL_FREE    = 2'd0;
    localparam logic [CELL_W-1:0] CELL_OCC     = 2'd1;
    localparam logic [CELL_W-1:0] CELL_UNKNOWN = 2'd2;
    localparam logic [CELL_W-1:0] CELL_BAD     = 2'd3;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUT_HIT     = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_UNKNOWN = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_BOUNDS  = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_CLEAR   = 3'd3;
    localparam logic [OUTC_W-1:0] OUT_WRITE   = 3'd4;

    // Result range sources
    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_MAX  = 2'd1;
    localparam logic [1:0] SRC_ROOT = 2'd2;

    typedef struct packed {
        logic              clr_en;
        logic              load;
        logic              wr_en;
        logic              rd_en;
        logic              step;
        logic              hit;
        logic              sq_start;
        logic              res_we;
        logic [OUTC_W-1:0] res_code;
        logic [1:0]        res_src;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic              clr_last;
        logic              is_write;
        logic              in_bounds;
        logic              at_end;
        logic              sq_done;
        logic [CELL_W-1:0] rd_state;
    } t_stat;

endpackage

// ----- rtl/grid_ray_cast_range_core.sv -----
`timescale 1ns / 1ps
// Cell write: the cell is written and the result set, then the result word goes to the
// output register. Cast: one grid memory read per visited cell, plus, on a hit, the
// multiplies and the bit-serial square root (28 root bits). One word is in work at a time.
// Reset is synchronous: after it the grid memory is swept to unknown, one cell per
// cycle, all GRID_SIDE*GRID_SIDE cells (65536 by default), with input stalled meanwhile.
module grid_ray_cast_range_core #(
    parameter int GRID_SIDE = grc_pkg::GRID_SIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [grc_pkg::OP_W-1:0]            i_operation,
    input  logic signed [grc_pkg::COORD_W-1:0]  i_start_x,
    input  logic signed [grc_pkg::COORD_W-1:0]  i_start_y,
    input  logic signed [grc_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [grc_pkg::COORD_W-1:0]  i_end_y,
    input  logic [grc_pkg::CELL_W-1:0]          i_cell_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [grc_pkg::RANGE_W-1:0]         o_range_q16,
    output logic [grc_pkg::OUTC_W-1:0]          o_outcome,
    input  logic                                i_cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [grc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import grc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    grc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    grc_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_operation  (i_operation),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_cell_value (i_cell_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_range_q16  (o_range_q16),
        .o_outcome    (o_outcome)
    );

endmodule

// ----- rtl/grc_sqrt.sv -----
`timescale 1ns / 1ps
// Bit-serial integer square root, one root bit per cycle.
module grc_sqrt #(
    parameter int IN_W = grc_pkg::SQ_IN_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IN_W-1:0]   i_radicand,
    output logic              o_done,
    output logic [IN_W/2-1:0] o_root
);
    import grc_pkg::*;

    localparam int RT_W  = IN_W / 2;
    localparam int REM_W = RT_W + 2;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic [IN_W-1:0]  r_x;
    logic [REM_W-1:0] r_rem;
    logic [RT_W-1:0]  r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    // Bring down the next two radicand bits and try the next root bit
    assign rem_sh = {r_rem[REM_W-3:0], r_x[IN_W-1:IN_W-2]};
    assign trial  = {r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Payload: operand shifter, partial remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= {r_x[IN_W-3:0], 2'b00};
            if (take) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[RT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[RT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- rtl/grc_dp.sv -----
`timescale 1ns / 1ps
// Datapath: grid memory, line walker, hit range arithmetic and result registers.
module grc_dp #(
    parameter int GRID_SIDE = grc_pkg::GRID_SIDE_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  grc_pkg::t_cmd                          i_cmd,
    output grc_pkg::t_stat                         o_stat,
    input  logic [grc_pkg::OP_W-1:0]               i_operation,
    input  logic signed [grc_pkg::COORD_W-1:0]     i_start_x,
    input  logic signed [grc_pkg::COORD_W-1:0]     i_start_y,
    input  logic signed [grc_pkg::COORD_W-1:0]     i_end_x,
    input  logic signed [grc_pkg::COORD_W-1:0]     i_end_y,
    input  logic [grc_pkg::CELL_W-1:0]             i_cell_value,
    input  logic                                   i_cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [grc_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output logic [grc_pkg::RANGE_W-1:0]            o_range_q16,
    output logic [grc_pkg::OUTC_W-1:0]             o_outcome
);
    import grc_pkg::*;

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(GRID_SIDE);
    localparam int DW     = COORD_W + 1;

    // Configuration registers
    logic [CSIZE_W-1:0] r_cell_size;
    logic [RANGE_W-1:0] r_max_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= CELL_SIZE_RST;
            r_max_range <= MAX_RANGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CELL_SIZE: r_cell_size <= i_cfg_data[CSIZE_W-1:0];
                CFG_MAX_RANGE: r_max_range <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Line setup from the incoming word
    logic signed [DW-1:0]  ddx, ddy;
    logic [COORD_W-1:0]    adx, ady;
    logic                  steep;

    assign ddx   = DW'(i_end_x) - DW'(i_start_x);
    assign ddy   = DW'(i_end_y) - DW'(i_start_y);
    assign adx   = ddx[DW-1] ? COORD_W'(-ddx) : ddx[COORD_W-1:0];
    assign ady   = ddy[DW-1] ? COORD_W'(-ddy) : ddy[COORD_W-1:0];
    assign steep = (i_operation != OP_WRITE) && (ady > adx);

    // Walker state
    logic                      r_is_write;
    logic [CELL_W-1:0]         r_val;
    logic signed [COORD_W-1:0] r_sx, r_sy;
    logic signed [COORD_W-1:0] r_a, r_b, r_a1;
    logic [COORD_W-1:0]        r_da, r_db;
    logic signed [DW:0]        r_err;
    logic                      r_aneg, r_bneg, r_steep;

    logic signed [COORD_W-1:0] a0, b0, a1, b1;
    assign a0 = steep ? i_start_y : i_start_x;
    assign b0 = steep ? i_start_x : i_start_y;
    assign a1 = steep ? i_end_y : i_end_x;
    assign b1 = steep ? i_end_x : i_end_y;

    logic signed [DW:0]   err_add;
    logic signed [DW+1:0] err_dbl;
    logic signed [DW+1:0] da_ext;
    assign err_add = r_err + $signed({2'b00, r_db});
    assign err_dbl = {err_add, 1'b0};
    assign da_ext  = $signed({3'b000, r_da});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_write <= (i_operation == OP_WRITE);
            r_val      <= (i_cell_value == CELL_BAD) ? CELL_UNKNOWN : i_cell_value;
            r_sx       <= i_start_x;
            r_sy       <= i_start_y;
            r_steep    <= steep;
            r_a        <= a0;
            r_b        <= b0;
            r_a1       <= a1;
            r_da       <= steep ? ady : adx;
            r_db       <= steep ? adx : ady;
            r_aneg     <= !(a0 < a1);
            r_bneg     <= !(b0 < b1);
            r_err      <= '0;
        end else if (i_cmd.step) begin
            r_a <= r_aneg ? r_a - COORD_W'(1) : r_a + COORD_W'(1);
            if (err_dbl >= da_ext) begin
                r_b   <= r_bneg ? r_b - COORD_W'(1) : r_b + COORD_W'(1);
                r_err <= err_add - $signed({2'b00, r_da});
            end else begin
                r_err <= err_add;
            end
        end
    end

    // Current cell in column/row order, bounds and address
    logic signed [COORD_W-1:0] col, row;
    logic                      in_bounds;
    logic [ADDR_W-1:0]         cell_addr;

    assign col = r_steep ? r_b : r_a;
    assign row = r_steep ? r_a : r_b;
    assign in_bounds = !col[COORD_W-1] && !row[COORD_W-1]
                    && ({1'b0, col[COORD_W-2:0]} < COORD_W'(GRID_SIDE))
                    && ({1'b0, row[COORD_W-2:0]} < COORD_W'(GRID_SIDE));
    assign cell_addr = ADDR_W'(ADDR_W'(row[COL_W-1:0]) * ADDR_W'(GRID_SIDE))
                     + ADDR_W'(col[COL_W-1:0]);

    // Grid memory with clearing sweep
    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_mem[r_clr_addr] <= CELL_UNKNOWN;
        end else if (i_cmd.wr_en && in_bounds) begin
            r_mem[cell_addr] <= r_val;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[cell_addr];
        end
    end

    // Hit range: |d| capture, squares, sum, two scalings by cell size
    logic signed [DW-1:0] hdx, hdy;
    logic [MAG_W-1:0]     r_mx, r_my;
    logic [SQ_W-1:0]      r_sqx, r_sqy;
    logic [D2_W-1:0]      r_d2;
    logic [P1_W-1:0]      r_p1;
    logic [P2_W-1:0]      r_p2;

    assign hdx = DW'(col) - DW'(r_sx);
    assign hdy = DW'(row) - DW'(r_sy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.hit) begin
            r_mx <= hdx[DW-1] ? MAG_W'(-hdx) : hdx[MAG_W-1:0];
            r_my <= hdy[DW-1] ? MAG_W'(-hdy) : hdy[MAG_W-1:0];
        end
        r_sqx <= r_mx * r_mx;
        r_sqy <= r_my * r_my;
        r_d2  <= D2_W'(r_sqx) + D2_W'(r_sqy);
        r_p1  <= r_d2 * r_cell_size;
        r_p2  <= r_p1 * r_cell_size;
    end

    logic              sq_done;
    logic [ROOT_W-1:0] root;

    grc_sqrt #(
        .IN_W (SQ_IN_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sq_start),
        .i_radicand ({1'b0, r_p2}),
        .o_done     (sq_done),
        .o_root     (root)
    );

    // Result and output registers
    logic [RANGE_W-1:0] root_sat;
    logic [RANGE_W-1:0] res_range;
    logic [RANGE_W-1:0] r_res_range;
    logic [OUTC_W-1:0]  r_res_code;

    assign root_sat = (|root[ROOT_W-1:RANGE_W]) ? RANGE_SAT : root[RANGE_W-1:0];

    always_comb begin
        case (i_cmd.res_src)
            SRC_ZERO: res_range = '0;
            SRC_MAX:  res_range = r_max_range;
            SRC_ROOT: res_range = root_sat;
            default:  res_range = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_we) begin
            r_res_range <= res_range;
            r_res_code  <= i_cmd.res_code;
        end
        if (i_cmd.out_load) begin
            o_range_q16 <= r_res_range;
            o_outcome   <= r_res_code;
        end
    end

    // Status to the controller
    assign o_stat.clr_last  = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_stat.is_write  = r_is_write;
    assign o_stat.in_bounds = in_bounds;
    assign o_stat.at_end    = (r_a == r_a1);
    assign o_stat.sq_done   = sq_done;
    assign o_stat.rd_state  = r_rd;

endmodule

// ----- rtl/grc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences clearing, writes, the cell walk, hit math and the result word.
module grc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    output grc_pkg::t_cmd  o_cmd,
    input  grc_pkg::t_stat i_stat
);
    import grc_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_H1   = 4'd4;
    localparam logic [3:0] S_H2   = 4'd5;
    localparam logic [3:0] S_H3   = 4'd6;
    localparam logic [3:0] S_H4   = 4'd7;
    localparam logic [3:0] S_SQS  = 4'd8;
    localparam logic [3:0] S_SQW  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_ovalid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            // Write the cell, or bounds-check and read the current cell
            S_RD: begin
                if (i_stat.is_write) begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_code = OUT_WRITE;
                    o_cmd.res_src  = SRC_ZERO;
                    n_state        = S_FIN;
                end else if (!i_stat.in_bounds) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_code = OUT_BOUNDS;
                    o_cmd.res_src  = SRC_MAX;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CHK;
                end
            end
            // Judge the cell state, then step along the line
            S_CHK: begin
                if (i_stat.rd_state == CELL_OCC) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_H1;
                end else if (i_stat.rd_state != CELL_FREE) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_code = OUT_UNKNOWN;
                    o_cmd.res_src  = SRC_MAX;
                    n_state        = S_FIN;
                end else if (i_stat.at_end) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_code = OUT_CLEAR;
                    o_cmd.res_src  = SRC_MAX;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_H1: n_state = S_H2;
            S_H2: n_state = S_H3;
            S_H3: n_state = S_H4;
            S_H4: n_state = S_SQS;
            S_SQS: begin
                o_cmd.sq_start = 1'b1;
                n_state        = S_SQW;
            end
            S_SQW: begin
                if (i_stat.sq_done) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_code = OUT_HIT;
                    o_cmd.res_src  = SRC_ROOT;
                    n_state        = S_FIN;
                end
            end
            // Hand the result to the output register once it is free
            S_FIN: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

endmodule
